// ===== hw/rtl/overwriting_rx_ring_buffer_macros.svh =====
// Assertion macros for the overwriting receive ring checker.
`ifndef OVERWRITING_RX_RING_BUFFER_MACROS_SVH
`define OVERWRITING_RX_RING_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ORRB_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orrb assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ORRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("orrb assertion failed");

`endif

// ===== hw/rtl/orrb_pkg.sv =====
// Shared types and codes for the overwriting receive ring.
package orrb_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_UNGET = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Result of one request as it leaves the pointer stage.
    typedef struct packed {
        status_t    status;
        logic       get_ok;
        logic [7:0] count;
    } s1_res_t;

endpackage

// ===== hw/rtl/orrb_mem.sv =====
// Byte store: one write port, one read port with registered read data.
module orrb_mem #(
    parameter int DEPTH = 256,
    parameter int PW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [PW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [PW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // held while stalled: only a new get reloads it
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/orrb_ctrl.sv =====
// Head/tail pointer logic, memory request generation and result stage.
module orrb_ctrl #(
    parameter int DEPTH = 256,
    parameter int PW    = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_op,
    input  logic [7:0]       in_byte,
    input  logic             out_free,
    output logic             s1_valid,
    output orrb_pkg::s1_res_t s1_res,
    output logic             mem_we,
    output logic [PW-1:0]    mem_waddr,
    output logic [7:0]       mem_wdata,
    output logic             mem_re,
    output logic [PW-1:0]    mem_raddr
);

    localparam int CNTW = (PW + 1 > 8) ? PW + 1 : 8;

    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic              s1_valid_reg, s1_valid_next;
    orrb_pkg::s1_res_t s1_reg, s1_next;
    logic              accept;
    logic [CNTW-1:0]   held;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_re         = 1'b0;
        mem_raddr      = rp_reg;
        mem_wdata      = in_byte;
        s1_next.status = orrb_pkg::ST_OK;
        s1_next.get_ok = 1'b0;
        unique case (orrb_pkg::op_t'(in_op))
            orrb_pkg::OP_PUT:
            begin
                mem_we  = accept;
                wp_next = ptr_inc(wp_reg);
                // head caught the tail: drop the oldest byte
                if (wp_next == rp_reg)
                begin
                    rp_next        = ptr_inc(rp_reg);
                    s1_next.status = orrb_pkg::ST_OVERFLOW;
                end
            end
            orrb_pkg::OP_GET:
            begin
                if (wp_reg == rp_reg)
                begin
                    s1_next.status = orrb_pkg::ST_EMPTY;
                end
                else
                begin
                    mem_re         = accept;
                    rp_next        = ptr_inc(rp_reg);
                    s1_next.get_ok = 1'b1;
                end
            end
            orrb_pkg::OP_UNGET:
            begin
                rp_next   = ptr_dec(rp_reg);
                mem_we    = accept;
                mem_waddr = rp_next;
                // tail wrapped onto the head: drop the newest byte
                if (wp_reg == rp_next)
                begin
                    wp_next        = ptr_dec(wp_reg);
                    s1_next.status = orrb_pkg::ST_OVERFLOW;
                end
            end
            orrb_pkg::OP_CLEAR:
            begin
                wp_next = '0;
                rp_next = '0;
            end
            default:
            begin
                wp_next = wp_reg;
            end
        endcase
        held = CNTW'(wp_next) - CNTW'(rp_next)
             + ((wp_next < rp_next) ? CNTW'(DEPTH) : CNTW'(0));
        s1_next.count = held[7:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                wp_reg <= wp_next;
                rp_reg <= rp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_res   = s1_reg;

endmodule

// ===== hw/rtl/overwriting_rx_ring_buffer.sv =====
// Overwriting receive ring of DEPTH bytes: one request per cycle unless the
// result path stalls. The pointer stage updates head and tail and issues the
// byte store access in the accept cycle; its result and the store's registered
// read data go to the output register, which lets a new request in while a
// result waits. Put on a full ring drops the oldest byte, unget on a full ring
// drops the newest; both report overflow. At most DEPTH-1 bytes are held.
module overwriting_rx_ring_buffer #(
    parameter int DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int PW = $clog2(DEPTH);

    logic              out_free;
    logic              s1_valid;
    orrb_pkg::s1_res_t s1_res;
    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata;

    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_data_reg;
    logic [1:0]        m_user_reg;
    logic              load;

    orrb_ctrl #(
        .DEPTH(DEPTH),
        .PW   (PW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .out_free (out_free),
        .s1_valid (s1_valid),
        .s1_res   (s1_res),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr)
    );

    orrb_mem #(
        .DEPTH(DEPTH),
        .PW   (PW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign out_free = !m_valid_reg || m_axis_tready;
    assign load     = s1_valid && out_free;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_data_reg <= {s1_res.count, s1_res.get_ok ? mem_rdata : 8'd0};
            m_user_reg <= s1_res.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== hw/rtl/orrb_checker.sv =====
// Port-level checks on the result stream of the overwriting receive ring.
`include "overwriting_rx_ring_buffer_macros.svh"

module orrb_checker #(
    parameter int DEPTH = 256
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    `ORRB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // empty get returns no byte and a zero count
    `ORRB_ASSERT_IMM(a_empty_zero, m_axis_tvalid && (m_axis_tuser == orrb_pkg::ST_EMPTY), m_axis_tdata == 16'd0)

    // overflow only happens at full, and carries no byte
    `ORRB_ASSERT_IMM(a_ovf_full, m_axis_tvalid && (m_axis_tuser == orrb_pkg::ST_OVERFLOW), (m_axis_tdata[15:8] == 8'(DEPTH - 1)) && (m_axis_tdata[7:0] == 8'd0))

endmodule

bind overwriting_rx_ring_buffer orrb_checker #(.DEPTH(DEPTH)) u_orrb_checker (.*);
